// File: hw/rtl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared widths, field codes and register indexes of the
// shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int PID_W      = 8;
    localparam int REM_W      = 16;
    localparam int TMR_W      = 4;
    localparam int CNT_W      = 8;

    // stream payload widths
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int OUT_BITS   = 37;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IO_WAIT_TICKS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PROCESSES = CFG_IDX_W'(1);

    localparam logic [TMR_W-1:0] IO_WAIT_RESET = TMR_W'(3);

    // request kinds on s_tuser
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // result bit positions inside m_tdata
    localparam int OB_STATUS   = 0;
    localparam int OB_RUN_V    = 1;
    localparam int OB_IO_START = 26;
    localparam int OB_FIN_V    = 27;

    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [REM_W-1:0] remaining;
        logic [TMR_W-1:0] timer;
    } slot_entry_t;

endpackage

// File: hw/rtl/shortest_remaining_time_scheduler.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive shortest-remaining-time-first scheduler over SLOTS process slots.
// ----------------------------------------------------------------------------
// Requests come in on the s_ stream. s_tuser selects the kind: an arrival
// loads process_id and burst_time into the lowest free slot, a tick ages the
// I/O timers, picks the ready slot with least remaining time (lowest slot on
// ties) and then retires, runs or blocks it. Every request gives exactly one
// result on the m_ stream. Registers are written on the cfg_ channel, which
// is always ready; write them only while the block is idle.
// Process id, remaining time and timer live in one RAM with registered read;
// used and waiting flags are flip-flops.
// An arrival goes from accept straight to the done state; a tick walks
// the slots (one RAM read per slot, pipelined with the timer write-back),
// then updates the pick in its own state before the done state. One
// request is in work at a time; s_tready is high only while the block is
// idle, so a new request is taken only once the last result is registered.
// The result sits in an output register, so the next request is accepted
// while m_ waits; a finished result stalls in the block while that register
// is still full. Reset frees all slots, clears the retired count, sets
// io_wait_ticks to 3 and total_processes to 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler #(
    parameter int SLOTS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // process_id[7:0], burst_time[23:8], io_event[24], zero[31:25]
    input  logic [srtf_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[0]
    input  logic                             s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[0], running_valid[1], running_id[9:2], remaining_left[25:10],
    // io_started[26], finished_valid[27], finished_id[35:28], all_done[36],
    // zero[39:37]
    output logic [srtf_pkg::M_TDATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [srtf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srtf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import srtf_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    typedef struct packed {
        logic             status;
        logic             running_valid;
        logic [PID_W-1:0] running_id;
        logic [REM_W-1:0] remaining_left;
        logic             io_started;
        logic             finished_valid;
        logic [PID_W-1:0] finished_id;
    } result_t;

    // control state
    logic [1:0]       state_reg, state_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [SLOTS-1:0] waiting_reg, waiting_next;
    logic [CNT_W-1:0] retired_reg, retired_next;
    logic [TMR_W-1:0] io_wait_reg, io_wait_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             issue_reg, issue_next;
    logic             chk_valid_reg, chk_valid_next;
    logic             best_valid_reg, best_valid_next;

    // payload
    logic [SLOT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [SLOT_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [SLOT_W-1:0]    best_idx_reg, best_idx_next;
    logic [REM_W-1:0]     best_rem_reg, best_rem_next;
    logic [PID_W-1:0]     best_pid_reg, best_pid_next;
    logic                 io_reg, io_next;
    result_t              res_reg, res_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // memory port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    slot_entry_t       ram_wdata;
    logic              ram_re;
    slot_entry_t       ram_rdata;

    // lowest free slot
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;

    // walk helpers
    logic chk_used;
    logic chk_wait;
    logic chk_expire;
    logic chk_ready;

    srtf_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign chk_used   = used_reg[chk_idx_reg];
    assign chk_wait   = waiting_reg[chk_idx_reg];
    assign chk_expire = ram_rdata.timer <= TMR_W'(1);
    assign chk_ready  = chk_used && (!chk_wait || chk_expire);

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        waiting_next    = waiting_reg;
        retired_next    = retired_reg;
        io_wait_next    = io_wait_reg;
        total_next      = total_reg;
        m_tvalid_next   = m_tvalid_reg;
        issue_next      = issue_reg;
        chk_valid_next  = 1'b0;
        best_valid_next = best_valid_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        best_idx_next   = best_idx_reg;
        best_rem_next   = best_rem_reg;
        best_pid_next   = best_pid_reg;
        io_next         = io_reg;
        res_next        = res_reg;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_re          = 1'b0;

        if (cfg_valid) begin
            case (cfg_index)
                REG_IO_WAIT_TICKS:   io_wait_next = cfg_data[TMR_W-1:0];
                REG_TOTAL_PROCESSES: total_next   = cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    res_next = '0;
                    if (s_tuser == ACT_ARRIVE) begin
                        if (free_found) begin
                            ram_we                 = 1'b1;
                            ram_waddr              = free_idx;
                            ram_wdata.pid          = s_tdata[7:0];
                            ram_wdata.remaining    = s_tdata[23:8];
                            ram_wdata.timer        = '0;
                            used_next[free_idx]    = 1'b1;
                            waiting_next[free_idx] = 1'b0;
                        end else begin
                            res_next.status = 1'b1;
                        end
                        state_next = ST_DONE;
                    end else begin
                        io_next         = s_tdata[24];
                        issue_next      = 1'b1;
                        rd_idx_next     = '0;
                        best_valid_next = 1'b0;
                        state_next      = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (issue_reg) begin
                    ram_re         = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg;
                    if (rd_idx_reg == LAST_SLOT) begin
                        issue_next = 1'b0;
                    end else begin
                        rd_idx_next = rd_idx_reg + SLOT_W'(1);
                    end
                end
                if (chk_valid_reg) begin
                    // age the timer of a blocked slot and write it back
                    if (chk_used && chk_wait) begin
                        ram_we          = 1'b1;
                        ram_waddr       = chk_idx_reg;
                        ram_wdata       = ram_rdata;
                        if (chk_expire) begin
                            ram_wdata.timer           = '0;
                            waiting_next[chk_idx_reg] = 1'b0;
                        end else begin
                            ram_wdata.timer = ram_rdata.timer - TMR_W'(1);
                        end
                    end
                    // strict less-than keeps the lowest slot on ties
                    if (chk_ready &&
                        (!best_valid_reg || ram_rdata.remaining < best_rem_reg)) begin
                        best_valid_next = 1'b1;
                        best_idx_next   = chk_idx_reg;
                        best_rem_next   = ram_rdata.remaining;
                        best_pid_next   = ram_rdata.pid;
                    end
                    if (chk_idx_reg == LAST_SLOT) begin
                        state_next = ST_PICK;
                    end
                end
            end
            ST_PICK: begin
                if (best_valid_reg) begin
                    if (best_rem_reg == '0) begin
                        used_next[best_idx_reg]    = 1'b0;
                        waiting_next[best_idx_reg] = 1'b0;
                        res_next.finished_valid    = 1'b1;
                        res_next.finished_id       = best_pid_reg;
                        if (retired_reg != '1) begin
                            retired_next = retired_reg + CNT_W'(1);
                        end
                    end else begin
                        ram_we                  = 1'b1;
                        ram_waddr               = best_idx_reg;
                        ram_wdata.pid           = best_pid_reg;
                        ram_wdata.remaining     = best_rem_reg - REM_W'(1);
                        ram_wdata.timer         = io_reg ? io_wait_reg : '0;
                        res_next.running_valid  = 1'b1;
                        res_next.running_id     = best_pid_reg;
                        res_next.remaining_left = best_rem_reg - REM_W'(1);
                        if (io_reg) begin
                            waiting_next[best_idx_reg] = 1'b1;
                            res_next.io_started        = 1'b1;
                        end
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_TDATA_W - OUT_BITS){1'b0}},
                                     (retired_reg >= total_reg),
                                     res_reg.finished_id,
                                     res_reg.finished_valid,
                                     res_reg.io_started,
                                     res_reg.remaining_left,
                                     res_reg.running_id,
                                     res_reg.running_valid,
                                     res_reg.status};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            waiting_reg    <= '0;
            retired_reg    <= '0;
            io_wait_reg    <= IO_WAIT_RESET;
            total_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
            issue_reg      <= 1'b0;
            chk_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            waiting_reg    <= waiting_next;
            retired_reg    <= retired_next;
            io_wait_reg    <= io_wait_next;
            total_reg      <= total_next;
            m_tvalid_reg   <= m_tvalid_next;
            issue_reg      <= issue_next;
            chk_valid_reg  <= chk_valid_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        best_idx_reg <= best_idx_next;
        best_rem_reg <= best_rem_next;
        best_pid_reg <= best_pid_next;
        io_reg       <= io_next;
        res_reg      <= res_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

endmodule

// File: hw/rtl/srtf_ram.sv
// ----------------------------------------------------------------------------
// srtf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/srtf_checker.sv
// ----------------------------------------------------------------------------
// srtf_port_checker
// Port-level checks of the shortest-remaining-time scheduler, bound to the
// top level.
// ----------------------------------------------------------------------------
module srtf_port_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [srtf_pkg::M_TDATA_W-1:0] m_tdata
);

    import srtf_pkg::*;

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // a tick either runs or retires, never both; a dropped arrival does neither
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[OB_RUN_V] && m_tdata[OB_FIN_V]) &&
                     !(m_tdata[OB_STATUS] && (m_tdata[OB_RUN_V] || m_tdata[OB_FIN_V])))
        else $error("conflicting result flags");

    // only a running pick can start I/O
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[OB_IO_START] |-> m_tdata[OB_RUN_V])
        else $error("io started without a running pick");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind shortest_remaining_time_scheduler srtf_port_checker u_srtf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: test/srtf_checker.sv
// ----------------------------------------------------------------------------
// srtf_checker
// Watches the request, result and register channels of the scheduler, keeps
// its own copy of the slot table and compares every result field by field.
// ----------------------------------------------------------------------------
module srtf_checker #(
    parameter int SLOTS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // process_id[7:0], burst_time[23:8], io_event[24], zero[31:25]
    input  logic [srtf_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[0]
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // status[0], running_valid[1], running_id[9:2], remaining_left[25:10],
    // io_started[26], finished_valid[27], finished_id[35:28], all_done[36]
    input  logic [srtf_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [srtf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srtf_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                               bad_fields,
    output int                               reply_backlog
);

    import srtf_pkg::*;

    localparam int MAX_SHOWN = 10;

    // first member lands in the top bit, so status ends up at bit 0
    typedef struct packed {
        logic              all_done;
        logic [PID_W-1:0]  finished_id;
        logic              finished_valid;
        logic              io_started;
        logic [REM_W-1:0]  remaining_left;
        logic [PID_W-1:0]  running_id;
        logic              running_valid;
        logic              status;
    } sched_reply_t;

    logic              slot_used    [SLOTS];
    logic              slot_waiting [SLOTS];
    slot_entry_t       slot_info    [SLOTS];
    logic [CNT_W-1:0]  retired;
    logic [TMR_W-1:0]  io_wait;
    logic [CNT_W-1:0]  total_needed;
    sched_reply_t      reply_queue [$];
    int                result_idx;
    int                err_total;

    function automatic sched_reply_t apply_request(input logic kind,
                                                   input logic [PID_W-1:0] pid,
                                                   input logic [REM_W-1:0] burst,
                                                   input logic io);
        sched_reply_t r;
        int           pick;
        bit           placed;
        r      = '0;
        pick   = -1;
        placed = 1'b0;
        if (kind == ACT_ARRIVE) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (!placed && !slot_used[i]) begin
                    slot_used[i]           = 1'b1;
                    slot_waiting[i]        = 1'b0;
                    slot_info[i].pid       = pid;
                    slot_info[i].remaining = burst;
                    slot_info[i].timer     = '0;
                    placed                 = 1'b1;
                end
            end
            r.status = !placed;
        end else begin
            // age the i/o timers first, a timer of 0 or 1 ends the wait
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i] && slot_waiting[i]) begin
                    if (slot_info[i].timer <= 1) begin
                        slot_info[i].timer = '0;
                        slot_waiting[i]    = 1'b0;
                    end else begin
                        slot_info[i].timer = slot_info[i].timer - TMR_W'(1);
                    end
                end
            end
            // strict less-than keeps ties on the lowest slot
            for (int i = 0; i < SLOTS; i++) begin
                if (slot_used[i] && !slot_waiting[i]) begin
                    if (pick < 0 || slot_info[i].remaining < slot_info[pick].remaining)
                        pick = i;
                end
            end
            if (pick >= 0) begin
                if (slot_info[pick].remaining == '0) begin
                    slot_used[pick]    = 1'b0;
                    slot_waiting[pick] = 1'b0;
                    r.finished_valid   = 1'b1;
                    r.finished_id      = slot_info[pick].pid;
                    if (retired != '1)
                        retired = retired + CNT_W'(1);
                end else begin
                    slot_info[pick].remaining = slot_info[pick].remaining - REM_W'(1);
                    r.running_valid  = 1'b1;
                    r.running_id     = slot_info[pick].pid;
                    r.remaining_left = slot_info[pick].remaining;
                    if (io) begin
                        slot_waiting[pick]    = 1'b1;
                        slot_info[pick].timer = io_wait;
                        r.io_started          = 1'b1;
                    end
                end
            end
        end
        r.all_done = (retired >= total_needed);
        return r;
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_total++;
            if (err_total <= MAX_SHOWN)
                $display("result %0d: %s mismatch, expected 0x%0h, got 0x%0h",
                         result_idx, fname, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        sched_reply_t got;
        sched_reply_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_used[i]    = 1'b0;
                slot_waiting[i] = 1'b0;
                slot_info[i]    = '0;
            end
            retired      = '0;
            io_wait      = IO_WAIT_RESET;
            total_needed = '0;
            reply_queue.delete();
            result_idx   = 0;
            err_total    = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_IO_WAIT_TICKS)
                    io_wait = cfg_data[TMR_W-1:0];
                else if (cfg_index == REG_TOTAL_PROCESSES)
                    total_needed = cfg_data[CNT_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[OUT_BITS-1:0];
                if (reply_queue.size() == 0) begin
                    err_total++;
                    if (err_total <= MAX_SHOWN)
                        $display("result %0d: no request outstanding, got 0x%0h",
                                 result_idx, got);
                end else begin
                    want = reply_queue.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("running_valid", 32'(want.running_valid),
                                32'(got.running_valid));
                    check_field("running_id", 32'(want.running_id),
                                32'(got.running_id));
                    check_field("remaining_left", 32'(want.remaining_left),
                                32'(got.remaining_left));
                    check_field("io_started", 32'(want.io_started),
                                32'(got.io_started));
                    check_field("finished_valid", 32'(want.finished_valid),
                                32'(got.finished_valid));
                    check_field("finished_id", 32'(want.finished_id),
                                32'(got.finished_id));
                    check_field("all_done", 32'(want.all_done), 32'(got.all_done));
                end
                result_idx++;
            end
            if (s_tvalid && s_tready)
                reply_queue.push_back(apply_request(s_tuser, s_tdata[7:0],
                                                    s_tdata[23:8], s_tdata[24]));
        end
        bad_fields    <= err_total;
        reply_backlog <= reply_queue.size();
    end

endmodule

// File: test/tb_shortest_remaining_time_scheduler.sv
// ----------------------------------------------------------------------------
// tb_shortest_remaining_time_scheduler
// Drives arrivals and ticks with random gaps and back-pressure through
// several register settings; srtf_checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_shortest_remaining_time_scheduler;

    import srtf_pkg::*;

    localparam int SLOTS        = 8;
    localparam int CLK_PERIOD   = 8;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL         = 4 * (SLOTS + 4);
    localparam int PHASES       = 13;
    localparam int PHASE_LEN    = 148;
    localparam int LIMIT_CYCLES = 1_200_000;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [M_TDATA_W-1:0]     m_tdata;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    int                       bad_fields;
    int                       reply_backlog;
    bit                       hold_armed = 1'b0;
    bit                       no_gaps    = 1'b0;
    int                       big_left   = 2;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    shortest_remaining_time_scheduler #(
        .SLOTS(SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    srtf_checker #(
        .SLOTS(SLOTS)
    ) u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .bad_fields    (bad_fields),
        .reply_backlog (reply_backlog)
    );

    task automatic send_request(input logic kind, input logic [PID_W-1:0] pid,
                                input logic [REM_W-1:0] burst, input logic io);
        int gap;
        int roll;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'b0, io, burst, pid};
        do @(posedge aclk); while (!s_tready);
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 60)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else if (roll < 98)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 80);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // backlog is registered in the checker, so look at it from the next cycle on
    task automatic drain_replies();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reply_backlog != 0) @(posedge aclk);
    endtask

    initial begin : result_sink
        int span;
        int pattern;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_armed) begin
                // long hold-off so the output register fills and the input stalls
                hold_armed <= 1'b0;
                m_tready   <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                pattern = $urandom_range(0, 9);
                span    = $urandom_range(1, 30);
                if (pattern < 4) begin
                    m_tready <= 1'b1;
                    repeat (span) @(posedge aclk);
                end else if (pattern < 8) begin
                    repeat (span) begin
                        m_tready <= ($urandom_range(0, 1) == 1);
                        @(posedge aclk);
                    end
                end else if (pattern < 9) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 4)) @(posedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : stimulus
        logic [PID_W-1:0]  pid;
        logic [REM_W-1:0]  burst;
        logic              kind;
        logic              io;
        logic [TMR_W-1:0]  wait_v;
        logic [3:0]        hi;
        logic [CNT_W-1:0]  total_v;
        int                arrive_pct;
        int                roll;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ACT_ARRIVE;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // runs on the reset register values
        send_request(ACT_TICK,   8'h00, 16'h0000, 1'b1);   // empty table
        send_request(ACT_ARRIVE, 8'h00, 16'h0000, 1'b0);   // zero burst
        send_request(ACT_ARRIVE, 8'hFF, 16'hFFFF, 1'b0);
        send_request(ACT_ARRIVE, 8'hA5, 16'h0002, 1'b0);
        send_request(ACT_ARRIVE, 8'h5A, 16'h0002, 1'b0);   // tie with the one above
        send_request(ACT_TICK,   8'h00, 16'h0000, 1'b0);   // zero burst retires
        send_request(ACT_TICK,   8'h00, 16'h0000, 1'b1);
        send_request(ACT_TICK,   8'h00, 16'h0000, 1'b0);
        send_request(ACT_TICK,   8'h00, 16'h0000, 1'b1);
        send_request(ACT_TICK,   8'h00, 16'h0000, 1'b0);
        send_request(ACT_TICK,   8'h00, 16'h0000, 1'b0);
        // overfill the table
        for (int i = 0; i < 8; i++)
            send_request(ACT_ARRIVE, PID_W'(8'h10 + i), 16'((i % 4) + 1), 1'b0);
        for (int i = 0; i < 5; i++)
            send_request(ACT_TICK, 8'h00, 16'h0000, i[0]);
        big_left = 2;

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_replies();
            case (ph)
                0: begin
                    wait_v  = 4'd0;
                    total_v = 8'd255;
                end
                1: begin
                    wait_v  = 4'd15;
                    total_v = 8'd0;
                end
                2: begin
                    wait_v  = 4'd1;
                    total_v = 8'd255;
                end
                11: begin
                    wait_v  = TMR_W'($urandom_range(0, 15));
                    total_v = 8'd255;
                end
                12: begin
                    wait_v  = 4'd15;
                    total_v = 8'd1;
                end
                default: begin
                    wait_v  = TMR_W'($urandom_range(0, 15));
                    total_v = CNT_W'($urandom_range(0, 255));
                end
            endcase
            hi = 4'($urandom_range(0, 15));
            write_reg(REG_IO_WAIT_TICKS, {hi, wait_v});
            write_reg(REG_TOTAL_PROCESSES, total_v);
            // unused index, must leave both registers alone
            write_reg(CFG_IDX_W'($urandom_range(2, 15)),
                      CFG_DATA_W'($urandom_range(0, 255)));
            no_gaps = (ph % 5 == 2);
            if (ph == 3)
                hold_armed <= 1'b1;
            case (ph % 4)
                0:       arrive_pct = 30;
                1:       arrive_pct = 45;
                2:       arrive_pct = 20;
                default: arrive_pct = 70;
            endcase
            for (int k = 0; k < PHASE_LEN; k++) begin
                kind = ($urandom_range(0, 99) < arrive_pct) ? ACT_ARRIVE : ACT_TICK;
                pid  = PID_W'($urandom_range(0, 255));
                io   = ($urandom_range(0, 2) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 6)
                    burst = '0;
                else if (roll < 80)
                    burst = REM_W'($urandom_range(1, 8));
                else if (roll < 97)
                    burst = REM_W'($urandom_range(9, 64));
                else if (big_left > 0 && kind == ACT_ARRIVE) begin
                    // long jobs never finish, so only a couple of them
                    burst = REM_W'($urandom_range(256, 65535));
                    big_left--;
                end else
                    burst = REM_W'($urandom_range(1, 4));
                send_request(kind, pid, burst, io);
            end
        end

        drain_replies();
        repeat (TAIL) @(posedge aclk);
        if (bad_fields == 0 && reply_backlog == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/srtf_pkg.sv
hw/rtl/srtf_ram.sv
hw/rtl/shortest_remaining_time_scheduler.sv
hw/rtl/srtf_checker.sv
test/srtf_checker.sv
test/tb_shortest_remaining_time_scheduler.sv
